/* hw/rtl/s_record_stream_parser_assert.svh */
// assertion macros used by the checker file
`ifndef S_RECORD_STREAM_PARSER_ASSERT_SVH
`define S_RECORD_STREAM_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/srp_pkg.sv */
// ----------------------------------------------------------------------------
// srp_pkg
// Types, codes and character constants of the s-record stream parser.
// ----------------------------------------------------------------------------
package srp_pkg;

  // parser phases
  localparam logic [3:0] PH_WAIT = 4'd0;
  localparam logic [3:0] PH_TYPE = 4'd1;
  localparam logic [3:0] PH_S0   = 4'd2;
  localparam logic [3:0] PH_LEN  = 4'd3;
  localparam logic [3:0] PH_ADDR = 4'd4;
  localparam logic [3:0] PH_DATA = 4'd5;
  localparam logic [3:0] PH_CK   = 4'd6;
  localparam logic [3:0] PH_CR   = 4'd7;
  localparam logic [3:0] PH_LF   = 4'd8;

  // record types
  localparam logic [1:0] RT_S0 = 2'd0;
  localparam logic [1:0] RT_S3 = 2'd1;
  localparam logic [1:0] RT_S7 = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_HDR   = 3'd1;
  localparam logic [2:0] KIND_S3_OK = 3'd2;
  localparam logic [2:0] KIND_S7_OK = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NOT_S     = 3'd1;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd2;
  localparam logic [2:0] ERR_S0_FIELD  = 3'd3;
  localparam logic [2:0] ERR_LEN_SHORT = 3'd4;
  localparam logic [2:0] ERR_LINE_END  = 3'd5;
  localparam logic [2:0] ERR_CHECKSUM  = 3'd6;

  // characters
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_3  = 8'h33;
  localparam logic [7:0] CH_7  = 8'h37;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [7:0] S3_OVERHEAD   = 8'd5;
  localparam logic [4:0] S0_BODY_CHARS = 5'd28;
  localparam logic [4:0] ADDR_CHARS    = 5'd8;
  localparam logic [7:0] SUM_GOOD      = 8'hFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
  } res_t;

  // non-hex characters decode as zero
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d_num;
    logic [7:0] d_up;
    logic [7:0] d_lo;
    logic [3:0] n;
    d_num = c - 8'h30;
    d_up  = c - 8'h37;
    d_lo  = c - 8'h57;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = d_num[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n = d_up[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n = d_lo[3:0];
    end
    return n;
  endfunction

endpackage

/* hw/rtl/srp_ifs.sv */
// ----------------------------------------------------------------------------
// srp_ifs
// Handshake channels of the s-record stream parser.
// ----------------------------------------------------------------------------
interface srp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

interface srp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [31:0] address;
  logic [7:0]  data_byte;
  logic [2:0]  error_code;

  modport source (output valid, output result_kind, output address,
                  output data_byte, output error_code, input ready);
  modport sink   (input valid, input result_kind, input address,
                  input data_byte, input error_code, output ready);
endinterface

/* hw/rtl/s_record_stream_parser.sv */
// path: an accepted character passes the input register, then the parse logic
//   into the result register
// throughput: one character per cycle; the result register drains in the
//   same cycle it reloads, so only a stalled consumer slows the input
// reset: synchronous active-low rst_n returns to waiting for 'S', clears the
//   halt flag and empties both registers
// ----------------------------------------------------------------------------
// s_record_stream_parser
// Parses S0, S3 and S7 records one character at a time, emits each S3 data
// byte with its address and a verdict per record; halts on the first error.
// ----------------------------------------------------------------------------
module s_record_stream_parser (
  input  logic          clk,
  input  logic          rst_n,
  srp_char_if.sink      in_ch,
  srp_result_if.source  out_res
);

  logic          in_vld_r;
  logic [7:0]    in_char_r;
  logic          can_load;
  logic          adv;
  logic          res_vld;
  srp_pkg::res_t res;

  assign adv         = in_vld_r && can_load;
  assign in_ch.ready = !in_vld_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_char_r <= in_ch.in_char;
    end
  end

  srp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .ch      (in_char_r),
    .res_vld (res_vld),
    .res     (res)
  );

  srp_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv),
    .ld_vld   (res_vld),
    .ld_res   (res),
    .can_load (can_load),
    .out_res  (out_res)
  );

endmodule

/* hw/rtl/srp_parser.sv */
// ----------------------------------------------------------------------------
// srp_parser
// Record state machine: consumes one character per enable and gives at most
// one result in the same cycle.
// ----------------------------------------------------------------------------
module srp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [7:0]         ch,
  output logic               res_vld,
  output srp_pkg::res_t      res
);

  logic [3:0]  phase_r,   phase_nxt;
  logic [1:0]  rtype_r,   rtype_nxt;
  logic [4:0]  fc_r,      fc_nxt;
  logic [3:0]  hn_r,      hn_nxt;
  logic [31:0] addr_r,    addr_nxt;
  logic [7:0]  sum_r,     sum_nxt;
  logic [7:0]  left_r,    left_nxt;
  logic        halted_r,  halted_nxt;

  logic [3:0]  nib;
  logic [7:0]  byte_val;
  logic [7:0]  sum_add;
  logic [7:0]  left_dec;
  logic [4:0]  fc_inc;
  logic        odd;

  assign nib      = srp_pkg::hex_nibble(ch);
  assign byte_val = {hn_r, nib};
  assign sum_add  = sum_r + byte_val;
  assign left_dec = left_r - 8'd1;
  assign fc_inc   = fc_r + 5'd1;
  assign odd      = fc_r[0];

  always_comb begin
    phase_nxt  = phase_r;
    rtype_nxt  = rtype_r;
    fc_nxt     = fc_r;
    hn_nxt     = hn_r;
    addr_nxt   = addr_r;
    sum_nxt    = sum_r;
    left_nxt   = left_r;
    halted_nxt = halted_r;
    res_vld    = 1'b0;
    res.kind       = srp_pkg::KIND_ERROR;
    res.address    = 32'd0;
    res.data_byte  = 8'd0;
    res.error_code = srp_pkg::ERR_NONE;

    if (!halted_r) begin
      case (phase_r)
        srp_pkg::PH_WAIT: begin
          if (ch != srp_pkg::CH_S) begin
            res_vld = 1'b1;
            res.error_code = srp_pkg::ERR_NOT_S;
          end else begin
            phase_nxt = srp_pkg::PH_TYPE;
            fc_nxt    = 5'd0;
            sum_nxt   = 8'd0;
            addr_nxt  = 32'd0;
            left_nxt  = 8'd0;
            hn_nxt    = 4'd0;
          end
        end
        srp_pkg::PH_TYPE: begin
          fc_nxt = 5'd0;
          if (ch == srp_pkg::CH_0) begin
            rtype_nxt = srp_pkg::RT_S0;
            phase_nxt = srp_pkg::PH_S0;
          end else if (ch == srp_pkg::CH_3) begin
            rtype_nxt = srp_pkg::RT_S3;
            phase_nxt = srp_pkg::PH_LEN;
          end else if (ch == srp_pkg::CH_7) begin
            rtype_nxt = srp_pkg::RT_S7;
            phase_nxt = srp_pkg::PH_LEN;
          end else begin
            res_vld = 1'b1;
            res.error_code = srp_pkg::ERR_BAD_TYPE;
          end
        end
        srp_pkg::PH_S0: begin
          // fixed "0E0000" prefix of the header body
          if ((fc_r == 5'd0 && ch != srp_pkg::CH_0) ||
              (fc_r == 5'd1 && ch != srp_pkg::CH_E) ||
              (fc_r >= 5'd2 && fc_r <= 5'd5 && ch != srp_pkg::CH_0)) begin
            res_vld = 1'b1;
            res.error_code = srp_pkg::ERR_S0_FIELD;
          end else begin
            if (odd) sum_nxt = sum_add;
            else     hn_nxt  = nib;
            fc_nxt = fc_inc;
            if (fc_inc >= srp_pkg::S0_BODY_CHARS) begin
              fc_nxt    = 5'd0;
              phase_nxt = srp_pkg::PH_CK;
            end
          end
        end
        srp_pkg::PH_LEN: begin
          if (!odd) begin
            hn_nxt = nib;
            fc_nxt = 5'd1;
          end else begin
            sum_nxt   = sum_add;
            fc_nxt    = 5'd0;
            phase_nxt = srp_pkg::PH_ADDR;
            left_nxt  = 8'd0;
            if (rtype_r == srp_pkg::RT_S3) begin
              if (byte_val < srp_pkg::S3_OVERHEAD) begin
                res_vld = 1'b1;
                res.error_code = srp_pkg::ERR_LEN_SHORT;
              end else begin
                left_nxt = byte_val - srp_pkg::S3_OVERHEAD;
              end
            end
          end
        end
        srp_pkg::PH_ADDR: begin
          addr_nxt = {addr_r[27:0], nib};
          if (odd) sum_nxt = sum_add;
          else     hn_nxt  = nib;
          fc_nxt = fc_inc;
          if (fc_inc >= srp_pkg::ADDR_CHARS) begin
            fc_nxt = 5'd0;
            if (rtype_r == srp_pkg::RT_S3 && left_r != 8'd0) begin
              phase_nxt = srp_pkg::PH_DATA;
            end else begin
              phase_nxt = srp_pkg::PH_CK;
            end
          end
        end
        srp_pkg::PH_DATA: begin
          if (!odd) begin
            hn_nxt = nib;
            fc_nxt = 5'd1;
          end else begin
            fc_nxt   = 5'd0;
            sum_nxt  = sum_add;
            addr_nxt = addr_r + 32'd1;
            left_nxt = left_dec;
            if (left_dec == 8'd0) phase_nxt = srp_pkg::PH_CK;
            res_vld        = 1'b1;
            res.kind       = srp_pkg::KIND_DATA;
            res.address    = addr_r;
            res.data_byte  = byte_val;
          end
        end
        srp_pkg::PH_CK: begin
          if (!odd) begin
            hn_nxt = nib;
            fc_nxt = 5'd1;
          end else begin
            fc_nxt    = 5'd0;
            sum_nxt   = sum_add;
            phase_nxt = srp_pkg::PH_CR;
          end
        end
        srp_pkg::PH_CR: begin
          if (ch != srp_pkg::CH_CR) begin
            res_vld = 1'b1;
            res.error_code = srp_pkg::ERR_LINE_END;
          end else begin
            phase_nxt = srp_pkg::PH_LF;
          end
        end
        srp_pkg::PH_LF: begin
          res_vld = 1'b1;
          if (ch != srp_pkg::CH_LF) begin
            res.error_code = srp_pkg::ERR_LINE_END;
          end else if (sum_r != srp_pkg::SUM_GOOD) begin
            res.error_code = srp_pkg::ERR_CHECKSUM;
          end else begin
            phase_nxt = srp_pkg::PH_WAIT;
            case (rtype_r)
              srp_pkg::RT_S0: res.kind = srp_pkg::KIND_HDR;
              srp_pkg::RT_S3: res.kind = srp_pkg::KIND_S3_OK;
              default: begin
                res.kind    = srp_pkg::KIND_S7_OK;
                res.address = addr_r;
              end
            endcase
          end
        end
        default: begin
          phase_nxt = srp_pkg::PH_WAIT;
        end
      endcase

      // any error halts the parser until reset
      if (res_vld && res.kind == srp_pkg::KIND_ERROR) begin
        halted_nxt = 1'b1;
        phase_nxt  = srp_pkg::PH_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= srp_pkg::PH_WAIT;
      rtype_r  <= srp_pkg::RT_S0;
      fc_r     <= 5'd0;
      hn_r     <= 4'd0;
      addr_r   <= 32'd0;
      sum_r    <= 8'd0;
      left_r   <= 8'd0;
      halted_r <= 1'b0;
    end else if (en) begin
      phase_r  <= phase_nxt;
      rtype_r  <= rtype_nxt;
      fc_r     <= fc_nxt;
      hn_r     <= hn_nxt;
      addr_r   <= addr_nxt;
      sum_r    <= sum_nxt;
      left_r   <= left_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

/* hw/rtl/srp_out_reg.sv */
// ----------------------------------------------------------------------------
// srp_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module srp_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic                 ld_vld,
  input  srp_pkg::res_t        ld_res,
  output logic                 can_load,
  srp_result_if.source         out_res
);

  logic          vld_r, vld_nxt;
  srp_pkg::res_t res_r;

  // free when empty or being drained this cycle
  assign can_load = !vld_r || out_res.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = ld_vld;
    end else if (out_res.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ld_vld) begin
      res_r <= ld_res;
    end
  end

  assign out_res.valid       = vld_r;
  assign out_res.result_kind = res_r.kind;
  assign out_res.address     = res_r.address;
  assign out_res.data_byte   = res_r.data_byte;
  assign out_res.error_code  = res_r.error_code;

endmodule

/* hw/rtl/srp_checker.sv */
// ----------------------------------------------------------------------------
// srp_checker
// Port-level checks on the parser's result channel.
// ----------------------------------------------------------------------------
`include "s_record_stream_parser_assert.svh"

module srp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [31:0] out_address,
  input logic [7:0]  out_data_byte,
  input logic [2:0]  out_error_code
);

  logic err_seen_r;

  // an error request has left the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_valid && out_ready && out_kind == srp_pkg::KIND_ERROR) begin
      err_seen_r <= 1'b1;
    end
  end

  `SRP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_address) && $stable(out_data_byte) && $stable(out_error_code), "result changed while stalled")
  `SRP_ASSERT_NOW(a_code_only_on_error, out_valid && out_kind != srp_pkg::KIND_ERROR, out_error_code == srp_pkg::ERR_NONE, "error code on a non-error result")
  `SRP_ASSERT_NOW(a_byte_only_on_data, out_valid && out_kind != srp_pkg::KIND_DATA, out_data_byte == 8'd0, "data byte on a non-data result")
  `SRP_ASSERT_NOW(a_silent_after_error, err_seen_r, !out_valid, "result after an error")

endmodule

bind s_record_stream_parser srp_checker u_srp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_kind       (out_res.result_kind),
  .out_address    (out_res.address),
  .out_data_byte  (out_res.data_byte),
  .out_error_code (out_res.error_code)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Character-stream test of the s-record parser. Builds S0, S3 and S7 records
// with random content and idling, tracks the parse state alongside the block
// to predict every data byte and verdict, and ends each run with one broken
// record (or none) since an error halts the block until reset.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {FAULT_NONE, FAULT_CK, FAULT_CR, FAULT_LF} line_fault_t;

  logic clk;
  logic rst_n;

  srp_char_if   in_if();
  srp_result_if out_if();

  s_record_stream_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_res(out_if)
  );

  logic [7:0]      char_backlog[$];
  srp_pkg::res_t   expected_results[$];
  int unsigned     tx_idle_pct = 0;
  int unsigned     rx_stall_pct = 0;
  logic            rx_block = 1'b0;
  int              fail_count = 0;
  logic [7:0]      rec_sum;
  event            rx_hold_go;

  // parse state tracked alongside the block
  logic [3:0]  p_phase = srp_pkg::PH_WAIT;
  logic [1:0]  p_type = srp_pkg::RT_S0;
  logic [8:0]  p_count = '0;
  logic [3:0]  p_hi = '0;
  logic [7:0]  p_len = '0;
  logic [31:0] p_addr = '0;
  logic [7:0]  p_sum = '0;
  logic [7:0]  p_left = '0;
  logic        p_halted = 1'b0;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c[3:0];
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  task automatic expect_result(input logic [2:0] kind, input logic [31:0] addr,
                               input logic [7:0] data, input logic [2:0] code);
    srp_pkg::res_t r;
    r.kind = kind;
    r.address = addr;
    r.data_byte = data;
    r.error_code = code;
    expected_results.push_back(r);
  endtask

  task automatic flag_error(input logic [2:0] code);
    p_halted = 1'b1;
    p_phase = srp_pkg::PH_WAIT;
    expect_result(srp_pkg::KIND_ERROR, 32'h0, 8'h00, code);
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [3:0]  nib;
    logic [7:0]  val;
    logic        odd;
    logic [31:0] at;
    nib = nibble_of(c);
    val = {p_hi, nib};
    odd = p_count[0];
    at = p_addr;
    if (p_halted) return;
    case (p_phase)
      srp_pkg::PH_WAIT: begin
        if (c != srp_pkg::CH_S) begin
          flag_error(srp_pkg::ERR_NOT_S);
        end else begin
          p_phase = srp_pkg::PH_TYPE;
          p_count = '0;
          p_sum = '0;
          p_addr = '0;
          p_len = '0;
          p_left = '0;
          p_hi = '0;
        end
      end
      srp_pkg::PH_TYPE: begin
        p_count = '0;
        if (c == srp_pkg::CH_0) begin
          p_type = srp_pkg::RT_S0;
          p_phase = srp_pkg::PH_S0;
        end else if (c == srp_pkg::CH_3) begin
          p_type = srp_pkg::RT_S3;
          p_phase = srp_pkg::PH_LEN;
        end else if (c == srp_pkg::CH_7) begin
          p_type = srp_pkg::RT_S7;
          p_phase = srp_pkg::PH_LEN;
        end else begin
          flag_error(srp_pkg::ERR_BAD_TYPE);
        end
      end
      srp_pkg::PH_S0: begin
        // "0E" then "0000" must match exactly
        if ((p_count == 0 && c != srp_pkg::CH_0) || (p_count == 1 && c != srp_pkg::CH_E) ||
            (p_count >= 2 && p_count <= 5 && c != srp_pkg::CH_0)) begin
          flag_error(srp_pkg::ERR_S0_FIELD);
        end else begin
          if (odd) p_sum = p_sum + val;
          else p_hi = nib;
          p_count = p_count + 9'd1;
          if (p_count >= srp_pkg::S0_BODY_CHARS) begin
            p_count = '0;
            p_phase = srp_pkg::PH_CK;
          end
        end
      end
      srp_pkg::PH_LEN: begin
        if (!odd) begin
          p_hi = nib;
          p_count = 9'd1;
        end else begin
          p_len = val;
          p_sum = p_sum + val;
          p_count = '0;
          if (p_type == srp_pkg::RT_S3 && val < srp_pkg::S3_OVERHEAD) begin
            flag_error(srp_pkg::ERR_LEN_SHORT);
          end else begin
            p_left = (p_type == srp_pkg::RT_S3) ? val - srp_pkg::S3_OVERHEAD : 8'd0;
            p_phase = srp_pkg::PH_ADDR;
          end
        end
      end
      srp_pkg::PH_ADDR: begin
        p_addr = {p_addr[27:0], nib};
        if (odd) p_sum = p_sum + val;
        else p_hi = nib;
        p_count = p_count + 9'd1;
        if (p_count >= srp_pkg::ADDR_CHARS) begin
          p_count = '0;
          p_phase = (p_type == srp_pkg::RT_S3 && p_left != 0) ? srp_pkg::PH_DATA
                                                              : srp_pkg::PH_CK;
        end
      end
      srp_pkg::PH_DATA: begin
        if (!odd) begin
          p_hi = nib;
          p_count = 9'd1;
        end else begin
          p_count = '0;
          p_sum = p_sum + val;
          p_addr = p_addr + 32'd1;
          p_left = p_left - 8'd1;
          if (p_left == 0) p_phase = srp_pkg::PH_CK;
          expect_result(srp_pkg::KIND_DATA, at, val, srp_pkg::ERR_NONE);
        end
      end
      srp_pkg::PH_CK: begin
        if (!odd) begin
          p_hi = nib;
          p_count = 9'd1;
        end else begin
          p_count = '0;
          p_sum = p_sum + val;
          p_phase = srp_pkg::PH_CR;
        end
      end
      srp_pkg::PH_CR: begin
        if (c != srp_pkg::CH_CR) flag_error(srp_pkg::ERR_LINE_END);
        else p_phase = srp_pkg::PH_LF;
      end
      srp_pkg::PH_LF: begin
        // line end is judged before the checksum
        if (c != srp_pkg::CH_LF) begin
          flag_error(srp_pkg::ERR_LINE_END);
        end else if (p_sum != srp_pkg::SUM_GOOD) begin
          flag_error(srp_pkg::ERR_CHECKSUM);
        end else begin
          p_phase = srp_pkg::PH_WAIT;
          if (p_type == srp_pkg::RT_S0)
            expect_result(srp_pkg::KIND_HDR, 32'h0, 8'h00, srp_pkg::ERR_NONE);
          else if (p_type == srp_pkg::RT_S3)
            expect_result(srp_pkg::KIND_S3_OK, 32'h0, 8'h00, srp_pkg::ERR_NONE);
          else
            expect_result(srp_pkg::KIND_S7_OK, p_addr, 8'h00, srp_pkg::ERR_NONE);
        end
      end
      default: p_phase = srp_pkg::PH_WAIT;
    endcase
  endtask

  // ---------------------------------------------------------------- records

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  // mostly hex digits, now and then any character (decodes as zero if non-hex)
  function automatic logic [7:0] free_char();
    logic [7:0] c;
    if ($urandom_range(7) == 0) c = 8'($urandom_range(255));
    else c = hex_char(4'($urandom_range(15)));
    return c;
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] x);
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == x);
    return c;
  endfunction

  task automatic put_byte(input logic [7:0] v);
    char_backlog.push_back(hex_char(v[7:4]));
    char_backlog.push_back(hex_char(v[3:0]));
    rec_sum = rec_sum + v;
  endtask

  task automatic put_free_byte();
    logic [7:0] c1;
    logic [7:0] c2;
    c1 = free_char();
    c2 = free_char();
    char_backlog.push_back(c1);
    char_backlog.push_back(c2);
    rec_sum = rec_sum + {nibble_of(c1), nibble_of(c2)};
  endtask

  task automatic put_addr(input logic [31:0] addr);
    for (int i = 3; i >= 0; i--) put_byte(addr[8*i +: 8]);
  endtask

  task automatic finish_record(input line_fault_t fault);
    logic [7:0] ck;
    ck = ~rec_sum;
    // a broken line end sometimes carries a bad checksum too
    if (fault == FAULT_CK || (fault != FAULT_NONE && $urandom_range(1) == 1))
      ck = ck ^ 8'($urandom_range(1, 255));
    put_byte(ck);
    char_backlog.push_back(fault == FAULT_CR ? other_than(srp_pkg::CH_CR) : srp_pkg::CH_CR);
    char_backlog.push_back(fault == FAULT_LF ? other_than(srp_pkg::CH_LF) : srp_pkg::CH_LF);
  endtask

  task automatic gen_s0(input line_fault_t fault);
    char_backlog.push_back(srp_pkg::CH_S);
    char_backlog.push_back(srp_pkg::CH_0);
    char_backlog.push_back(srp_pkg::CH_0);
    char_backlog.push_back(srp_pkg::CH_E);
    repeat (4) char_backlog.push_back(srp_pkg::CH_0);
    rec_sum = 8'h0E;
    repeat (11) put_free_byte();
    finish_record(fault);
  endtask

  task automatic gen_s3(input logic [7:0] len, input logic [31:0] addr,
                        input line_fault_t fault);
    rec_sum = '0;
    char_backlog.push_back(srp_pkg::CH_S);
    char_backlog.push_back(srp_pkg::CH_3);
    put_byte(len);
    put_addr(addr);
    repeat (len - srp_pkg::S3_OVERHEAD) put_free_byte();
    finish_record(fault);
  endtask

  task automatic gen_s7(input logic [7:0] len, input logic [31:0] addr,
                        input line_fault_t fault);
    rec_sum = '0;
    char_backlog.push_back(srp_pkg::CH_S);
    char_backlog.push_back(srp_pkg::CH_7);
    put_byte(len);
    put_addr(addr);
    finish_record(fault);
  endtask

  function automatic logic [31:0] rand_addr();
    // near the top of the space so data addresses wrap
    if ($urandom_range(7) == 0) return 32'hFFFF_FFF0 | $urandom_range(15);
    return $urandom;
  endfunction

  task automatic gen_random_record(input line_fault_t fault);
    int unsigned pick;
    logic [7:0]  len;
    pick = $urandom_range(99);
    len = ($urandom_range(39) == 0) ? 8'd255 : 8'($urandom_range(5, 24));
    if (pick < 15) gen_s0(fault);
    else if (pick < 30) gen_s7(8'($urandom_range(255)), rand_addr(), fault);
    else gen_s3(len, rand_addr(), fault);
  endtask

  task automatic add_records(input int n_chars);
    int target;
    target = char_backlog.size() + n_chars;
    while (char_backlog.size() < target) gen_random_record(FAULT_NONE);
  endtask

  // one error at most per run: the block halts on it until reset
  task automatic break_stream();
    logic [2:0] err;
    logic [7:0] want;
    int         pos;
    err = 3'($urandom_range(6));
    case (err)
      srp_pkg::ERR_NOT_S: char_backlog.push_back(other_than(srp_pkg::CH_S));
      srp_pkg::ERR_BAD_TYPE: begin
        char_backlog.push_back(srp_pkg::CH_S);
        do want = 8'($urandom_range(255));
        while (want == srp_pkg::CH_0 || want == srp_pkg::CH_3 || want == srp_pkg::CH_7);
        char_backlog.push_back(want);
      end
      srp_pkg::ERR_S0_FIELD: begin
        pos = $urandom_range(5);
        char_backlog.push_back(srp_pkg::CH_S);
        char_backlog.push_back(srp_pkg::CH_0);
        for (int i = 0; i < pos; i++)
          char_backlog.push_back(i == 1 ? srp_pkg::CH_E : srp_pkg::CH_0);
        want = (pos == 1) ? srp_pkg::CH_E : srp_pkg::CH_0;
        char_backlog.push_back(other_than(want));
      end
      srp_pkg::ERR_LEN_SHORT: begin
        rec_sum = '0;
        char_backlog.push_back(srp_pkg::CH_S);
        char_backlog.push_back(srp_pkg::CH_3);
        put_byte(8'($urandom_range(4)));
      end
      srp_pkg::ERR_LINE_END: gen_random_record($urandom_range(1) ? FAULT_CR : FAULT_LF);
      srp_pkg::ERR_CHECKSUM: gen_random_record(FAULT_CK);
      default: ;
    endcase
    // ignored once halted
    repeat (8) char_backlog.push_back(8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (char_backlog.size() != 0 || in_if.valid || expected_results.size() != 0);
  endtask

  // ---------------------------------------------------------------- driver

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_char = 8'h00;
    out_if.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.in_char <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) parse_char(in_if.in_char);
      if (!in_if.valid || in_if.ready) begin
        if (char_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.in_char <= char_backlog.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !rx_block && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long consumer hold-off, counted here while the sender keeps offering
  initial begin : rx_hold
    forever begin
      @(rx_hold_go);
      rx_block = 1'b1;
      repeat (200) @(negedge clk);
      rx_block = 1'b0;
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    fail_count++;
    if (fail_count <= 40) $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
  endtask

  always @(posedge clk) begin : result_check
    srp_pkg::res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result_kind", 32'h0, 32'(out_if.result_kind));
      end else begin
        want = expected_results.pop_front();
        if (out_if.result_kind !== want.kind)
          report_mismatch("result_kind", 32'(want.kind), 32'(out_if.result_kind));
        if (out_if.address !== want.address)
          report_mismatch("address", want.address, out_if.address);
        if (out_if.data_byte !== want.data_byte)
          report_mismatch("data_byte", 32'(want.data_byte), 32'(out_if.data_byte));
        if (out_if.error_code !== want.error_code)
          report_mismatch("error_code", 32'(want.error_code), 32'(out_if.error_code));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // header, empty data record at zero, address wrap, entry points at both ends
    gen_s0(FAULT_NONE);
    gen_s3(8'd5, 32'h0000_0000, FAULT_NONE);
    gen_s3(8'd7, 32'hFFFF_FFFF, FAULT_NONE);
    gen_s7(8'h00, 32'h0000_0000, FAULT_NONE);
    gen_s7(8'hFF, 32'hFFFF_FFFF, FAULT_NONE);
    wait_drained();

    add_records(40);
    wait_drained();

    tx_idle_pct = 78;
    add_records(40);
    wait_drained();

    tx_idle_pct = 0;
    rx_stall_pct = 78;
    add_records(40);
    wait_drained();

    tx_idle_pct = 7;
    rx_stall_pct = 7;
    add_records(40);
    wait_drained();

    // consumer holds off while data requests keep coming
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (3) gen_s3(8'($urandom_range(12, 24)), rand_addr(), FAULT_NONE);
    -> rx_hold_go;
    @(negedge clk);
    wait (!rx_block);
    wait_drained();

    tx_idle_pct = 30;
    rx_stall_pct = 30;
    add_records(20);
    break_stream();
    wait_drained();
    repeat (20) @(negedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
